/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_REPEAT  = 2'd0,
    REG_CHATTER = 2'd1,
    REG_LONG    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } event_t;

  typedef struct packed {
    logic        repeat_enable;
    logic [15:0] chatter_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  localparam logic        RESET_REPEAT  = 1'b0;
  localparam logic [15:0] RESET_CHATTER = 16'd30;
  localparam logic [15:0] RESET_LONG    = 16'd1000;

endpackage

/* rtl/bpc_regs.sv */
`timescale 1ns / 1ps

module bpc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bpc_pkg::cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable <= bpc_pkg::RESET_REPEAT;
      cfg.chatter_ms    <= bpc_pkg::RESET_CHATTER;
      cfg.long_press_ms <= bpc_pkg::RESET_LONG;
    end else if (wr) begin
      case (idx)
        bpc_pkg::REG_REPEAT:  cfg.repeat_enable <= pwdata[0];
        bpc_pkg::REG_CHATTER: cfg.chatter_ms    <= pwdata[15:0];
        bpc_pkg::REG_LONG:    cfg.long_press_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::REG_REPEAT:  prdata = {31'd0, cfg.repeat_enable};
      bpc_pkg::REG_CHATTER: prdata = {16'd0, cfg.chatter_ms};
      bpc_pkg::REG_LONG:    prdata = {16'd0, cfg.long_press_ms};
      default:              prdata = '0;
    endcase
  end

endmodule

/* rtl/bpc_classify.sv */
`timescale 1ns / 1ps

module bpc_classify (
  input  logic          clk,
  input  logic          rst,
  input  bpc_pkg::cfg_t cfg,
  input  logic          step,
  input  logic          pin_level,
  input  logic [31:0]   now_ms,
  output logic [1:0]    event_next
);

  bpc_pkg::phase_t phase, phase_next;
  logic [31:0]     start_ms, start_ms_next;
  logic [31:0]     elapsed;
  logic            over_long, over_chatter;
  bpc_pkg::event_t ev;

  // modular difference handles timestamp wrap
  assign elapsed      = now_ms - start_ms;
  assign over_long    = elapsed > {16'd0, cfg.long_press_ms};
  assign over_chatter = elapsed > {16'd0, cfg.chatter_ms};

  always_comb begin
    phase_next    = phase;
    start_ms_next = start_ms;
    ev            = bpc_pkg::EV_NONE;
    if (!pin_level) begin
      case (phase)
        bpc_pkg::PH_RELEASED: begin
          phase_next    = bpc_pkg::PH_PRESSED;
          start_ms_next = now_ms;
        end
        bpc_pkg::PH_PRESSED: begin
          if (over_long) begin
            if (cfg.repeat_enable) begin
              phase_next = bpc_pkg::PH_REPEAT;
            end else begin
              phase_next = bpc_pkg::PH_LONG;
              ev         = bpc_pkg::EV_LONG;
            end
          end
        end
        bpc_pkg::PH_REPEAT: begin
          if (over_long) begin
            start_ms_next = now_ms;
            ev            = bpc_pkg::EV_REPEAT;
          end
        end
        default: ;
      endcase
    end else begin
      if (phase == bpc_pkg::PH_PRESSED && over_chatter) ev = bpc_pkg::EV_SHORT;
      phase_next = bpc_pkg::PH_RELEASED;
    end
  end

  assign event_next = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= bpc_pkg::PH_RELEASED;
      start_ms <= '0;
    end else if (step) begin
      phase    <= phase_next;
      start_ms <= start_ms_next;
    end
  end

endmodule

/* rtl/button_press_classifier_unit.sv */
`timescale 1ns / 1ps
// path: an accepted input beat passes the input register, then the result register, to its result beat
// throughput: one poll per cycle, held up only by back-pressure on the output
// input register and result register each hold one beat
// reset (rst, synchronous): phase released, start time zero, registers to defaults,
// both pipeline registers emptied

module button_press_classifier_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       pin_level,
  input  logic [31:0]                now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 event_res
);

  bpc_pkg::cfg_t cfg;
  logic          s1_valid;
  logic          s1_pin;
  logic [31:0]   s1_now;
  logic          out_free;
  logic          advance;
  logic [1:0]    event_next;

  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin <= pin_level;
      s1_now <= now_ms;
    end
  end

  bpc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .pin_level  (s1_pin),
    .now_ms     (s1_now),
    .event_next (event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) event_res <= event_next;
  end

endmodule

/* rtl/bpc_checker.sv */
`timescale 1ns / 1ps

module bpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown straight after reset");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .event_res (event_res)
);
